// ===== rtl/mpag_pkg.sv =====
// Shared types and constants of the modular preferential-attachment graph store.
`default_nettype none
package mpag_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int EDGE_W    = 13;
    localparam int DEG_W     = 8;
    localparam int ODEG_W    = 7;
    localparam int TAG_W     = 8;
    localparam int ALPHA_W   = 16;
    localparam int RINT_W    = 31;
    localparam int RFRAC_W   = 16;
    localparam int WGT_W     = 25;
    localparam int ACC_W     = 30;
    localparam int THR_W     = 46;

    localparam logic [2:0] REQ_NEW    = 3'd0;
    localparam logic [2:0] REQ_ADD    = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_CHOOSE = 3'd3;
    localparam logic [2:0] REQ_OUTE   = 3'd4;
    localparam logic [2:0] REQ_SOURCE = 3'd5;
    localparam logic [2:0] REQ_TEST   = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RDF,
        S_CHK,
        S_RDT,
        S_UPT,
        S_WALK,
        S_MUL,
        S_DIV,
        S_DIVW,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        PASS_SUM,
        PASS_SEL,
        PASS_CNT,
        PASS_PICK,
        PASS_SRC
    } pass_t;

    typedef struct packed {
        logic [MAX_NODES-1:0] row;
        logic [DEG_W-1:0]     deg;
        logic [ODEG_W-1:0]    outdeg;
        logic [TAG_W-1:0]     module_tag;
    } entry_t;

endpackage
`default_nettype wire

// ===== rtl/modular_pref_attach_graph_store.sv =====
// Top level of the modular preferential-attachment graph store.
// The block holds a directed graph of up to 64 nodes in one node table memory
// (adjacency row, degree, out-degree and module tag per node) plus edge and
// node counts, both zero after reset; rows are written clean when a node is
// created, so no clearing pass is needed. One request is taken at a time and
// every request yields exactly one result item. A target choice makes two
// walks over the N created nodes through the single table read port, with the
// threshold multiply between them; a source pick starts and runs the
// bit-serial remainder unit and then makes one walk; an out-edge pick counts
// the out-neighbours in one walk, runs the remainder unit and picks in a
// second walk. Input ready is high only while idle and returns in the cycle
// the result is loaded; a finished result waits in the output register
// without blocking the next item, and only a second result held up behind it
// stalls the sequencer in its final step. The user is to write the alpha
// register through the cfg channel only while the block is idle; the block
// itself does not enforce this.
`default_nettype none
module modular_pref_attach_graph_store (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // from_node[5:0], to_node[11:6], module_tag[19:12], random_int[50:20],
    // random_fraction[66:51], zero fill [71:67]
    input  wire logic [71:0] s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]  s_tuser,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // node_id[5:0], edge_total[18:6], node_total[25:19], zero fill [31:26]
    output logic [31:0]      m_tdata,
    // found[0], changed[1]
    output logic [1:0]       m_tuser,
    // alpha_q8 write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    mpag_pkg::state_t state_reg, state_next;
    mpag_pkg::pass_t  pass_reg, pass_next;

    // request payload
    logic [2:0]                        req_reg, req_next;
    logic [mpag_pkg::NODE_W-1:0]       f_reg, f_next;
    logic [mpag_pkg::NODE_W-1:0]       t_reg, t_next;
    logic [mpag_pkg::TAG_W-1:0]        mod_reg, mod_next;
    logic [mpag_pkg::RINT_W-1:0]       rint_reg, rint_next;
    logic [mpag_pkg::RFRAC_W-1:0]      rfrac_reg, rfrac_next;

    // graph state
    logic [mpag_pkg::CNT_W-1:0]        node_count_reg, node_count_next;
    logic [mpag_pkg::EDGE_W-1:0]       edge_count_reg, edge_count_next;
    logic [mpag_pkg::ALPHA_W-1:0]      alpha_reg, alpha_next;

    // walk engine
    logic [mpag_pkg::MAX_NODES-1:0]    row_reg, row_next;
    logic [mpag_pkg::TAG_W-1:0]        modf_reg, modf_next;
    logic [mpag_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic                              pv_reg, pv_next;
    logic [mpag_pkg::NODE_W-1:0]       pidx_reg, pidx_next;
    logic [mpag_pkg::ACC_W-1:0]        acc_reg, acc_next;
    logic [mpag_pkg::ACC_W-1:0]        pre_reg, pre_next;
    logic [mpag_pkg::THR_W-1:0]        thr_reg, thr_next;
    logic [mpag_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [mpag_pkg::EDGE_W-1:0]       s_reg, s_next;

    // result
    logic [mpag_pkg::NODE_W-1:0]       res_node_reg, res_node_next;
    logic                              res_found_reg, res_found_next;
    logic                              res_changed_reg, res_changed_next;
    logic                              m_valid_reg, m_valid_next;
    logic [31:0]                       m_data_reg, m_data_next;
    logic [1:0]                        m_user_reg, m_user_next;

    // node table
    mpag_pkg::entry_t                  mem [mpag_pkg::MAX_NODES];
    mpag_pkg::entry_t                  rdata_reg;
    mpag_pkg::entry_t                  mem_wdata;
    logic                              mem_we;
    logic [mpag_pkg::NODE_W-1:0]       mem_waddr;
    logic [mpag_pkg::NODE_W-1:0]       mem_raddr;

    // remainder unit
    logic                              div_start;
    logic                              div_done;
    logic [mpag_pkg::EDGE_W-1:0]       div_rem;
    logic [mpag_pkg::EDGE_W-1:0]       div_den;

    // decode and walk conditions
    logic                              in_acc;
    logic                              out_free;
    logic                              f_ok;
    logic                              ft_ok;
    logic                              bit_t;
    logic                              issue;
    logic                              walk_end;
    logic                              walk_hit;
    logic                              cand_choose;
    logic                              cand_edge;
    logic [16:0]                       alpha_plus;
    logic [mpag_pkg::WGT_W-1:0]        prod_w;
    logic [mpag_pkg::DEG_W:0]          deg_inc;
    logic [mpag_pkg::WGT_W-1:0]        weight;
    logic [mpag_pkg::ACC_W-1:0]        acc_add;
    logic [mpag_pkg::ACC_W-1:0]        pre_add;
    logic [mpag_pkg::EDGE_W-1:0]       s_add;
    logic [mpag_pkg::THR_W-1:0]        thr_prod;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign f_ok     = {1'b0, f_reg} < node_count_reg;
    assign ft_ok    = f_ok && ({1'b0, t_reg} < node_count_reg);
    assign bit_t    = rdata_reg.row[t_reg];

    // per-node weight and running sums for the node read in the previous cycle
    assign cand_choose = (pidx_reg != f_reg) && !row_reg[pidx_reg];
    assign cand_edge   = (pidx_reg != f_reg) && row_reg[pidx_reg];
    assign alpha_plus  = 17'd256 + {1'b0, alpha_reg};
    assign prod_w      = rdata_reg.deg * alpha_plus;
    assign deg_inc     = {1'b0, rdata_reg.deg} + 9'd1;
    assign weight      = (rdata_reg.module_tag == modf_reg) ? (prod_w + 25'd256)
                                                           : {8'b0, deg_inc, 8'b0};
    assign acc_add     = acc_reg + {5'b0, weight};
    assign pre_add     = pre_reg + {5'b0, weight};
    assign s_add       = s_reg + {6'b0, rdata_reg.outdeg};
    assign thr_prod    = rfrac_reg * acc_reg;

    assign issue    = idx_reg < node_count_reg;
    assign walk_end = !pv_reg && !issue;

    always_comb
    begin
        walk_hit = 1'b0;
        if (pv_reg)
        begin
            case (pass_reg)
                mpag_pkg::PASS_SEL:  walk_hit = cand_choose && ({pre_add, 16'b0} >= thr_reg);
                mpag_pkg::PASS_PICK: walk_hit = cand_edge && ({6'b0, cnt_reg} == div_rem);
                mpag_pkg::PASS_SRC:  walk_hit = s_add > div_rem;
                default:             walk_hit = 1'b0;
            endcase
        end
    end

    assign div_den = (req_reg == mpag_pkg::REQ_SOURCE) ? edge_count_reg : {6'b0, cnt_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpag_pkg::S_IDLE:
            begin
                if (in_acc)
                    state_next = mpag_pkg::S_DECODE;
            end
            mpag_pkg::S_DECODE:
            begin
                unique case (req_reg) inside
                    mpag_pkg::REQ_ADD, mpag_pkg::REQ_REMOVE, mpag_pkg::REQ_TEST:
                        state_next = ft_ok ? mpag_pkg::S_RDF : mpag_pkg::S_RESP;
                    mpag_pkg::REQ_CHOOSE, mpag_pkg::REQ_OUTE:
                        state_next = f_ok ? mpag_pkg::S_RDF : mpag_pkg::S_RESP;
                    mpag_pkg::REQ_SOURCE:
                        state_next = (edge_count_reg != '0) ? mpag_pkg::S_DIV
                                                            : mpag_pkg::S_RESP;
                    default:
                        state_next = mpag_pkg::S_RESP;
                endcase
            end
            mpag_pkg::S_RDF:
                state_next = mpag_pkg::S_CHK;
            mpag_pkg::S_CHK:
            begin
                unique case (req_reg) inside
                    mpag_pkg::REQ_ADD:
                        state_next = bit_t ? mpag_pkg::S_RESP : mpag_pkg::S_RDT;
                    mpag_pkg::REQ_REMOVE:
                        state_next = bit_t ? mpag_pkg::S_RDT : mpag_pkg::S_RESP;
                    mpag_pkg::REQ_CHOOSE, mpag_pkg::REQ_OUTE:
                        state_next = mpag_pkg::S_WALK;
                    default:
                        state_next = mpag_pkg::S_RESP;
                endcase
            end
            mpag_pkg::S_RDT:
                state_next = mpag_pkg::S_UPT;
            mpag_pkg::S_UPT:
                state_next = mpag_pkg::S_RESP;
            mpag_pkg::S_WALK:
            begin
                if (walk_hit)
                    state_next = mpag_pkg::S_RESP;
                else if (walk_end)
                begin
                    unique case (pass_reg)
                        mpag_pkg::PASS_SUM: state_next = mpag_pkg::S_MUL;
                        mpag_pkg::PASS_CNT: state_next = (cnt_reg != '0) ? mpag_pkg::S_DIV
                                                                         : mpag_pkg::S_RESP;
                        default:            state_next = mpag_pkg::S_RESP;
                    endcase
                end
            end
            mpag_pkg::S_MUL:
                state_next = mpag_pkg::S_WALK;
            mpag_pkg::S_DIV:
                state_next = mpag_pkg::S_DIVW;
            mpag_pkg::S_DIVW:
            begin
                if (div_done)
                    state_next = mpag_pkg::S_WALK;
            end
            mpag_pkg::S_RESP:
            begin
                if (out_free)
                    state_next = mpag_pkg::S_IDLE;
            end
            default:
                state_next = mpag_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next         = req_reg;
        f_next           = f_reg;
        t_next           = t_reg;
        mod_next         = mod_reg;
        rint_next        = rint_reg;
        rfrac_next       = rfrac_reg;
        node_count_next  = node_count_reg;
        edge_count_next  = edge_count_reg;
        alpha_next       = alpha_reg;
        pass_next        = pass_reg;
        row_next         = row_reg;
        modf_next        = modf_reg;
        idx_next         = idx_reg;
        pv_next          = 1'b0;
        pidx_next        = pidx_reg;
        acc_next         = acc_reg;
        pre_next         = pre_reg;
        thr_next         = thr_reg;
        cnt_next         = cnt_reg;
        s_next           = s_reg;
        res_node_next    = res_node_reg;
        res_found_next   = res_found_reg;
        res_changed_next = res_changed_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;
        mem_we           = 1'b0;
        mem_waddr        = f_reg;
        mem_wdata        = rdata_reg;
        mem_raddr        = idx_reg[mpag_pkg::NODE_W-1:0];
        div_start        = 1'b0;

        if (cfg_valid)
            alpha_next = cfg_data;

        unique case (state_reg)
            mpag_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next   = s_tuser;
                    f_next     = s_tdata[5:0];
                    t_next     = s_tdata[11:6];
                    mod_next   = s_tdata[19:12];
                    rint_next  = s_tdata[50:20];
                    rfrac_next = s_tdata[66:51];
                end
            end
            mpag_pkg::S_DECODE:
            begin
                res_node_next    = '0;
                res_found_next   = 1'b0;
                res_changed_next = 1'b0;
                // create: write a clean row for the new node
                if (req_reg == mpag_pkg::REQ_NEW &&
                    node_count_reg < mpag_pkg::CNT_W'(mpag_pkg::MAX_NODES))
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = node_count_reg[mpag_pkg::NODE_W-1:0];
                    mem_wdata            = '0;
                    mem_wdata.module_tag = mod_reg;
                    res_node_next        = node_count_reg[mpag_pkg::NODE_W-1:0];
                    res_found_next       = 1'b1;
                    node_count_next      = node_count_reg + 7'd1;
                end
                if (req_reg == mpag_pkg::REQ_SOURCE)
                    div_start = 1'b0;
            end
            mpag_pkg::S_RDF:
                mem_raddr = f_reg;
            mpag_pkg::S_CHK:
            begin
                idx_next  = '0;
                acc_next  = '0;
                cnt_next  = '0;
                row_next  = rdata_reg.row;
                modf_next = rdata_reg.module_tag;
                unique case (req_reg)
                    mpag_pkg::REQ_TEST:
                        res_found_next = bit_t;
                    mpag_pkg::REQ_ADD:
                    begin
                        if (!bit_t)
                        begin
                            mem_we                = 1'b1;
                            mem_wdata.row[t_reg]  = 1'b1;
                            mem_wdata.deg         = rdata_reg.deg + 8'd1;
                            mem_wdata.outdeg      = rdata_reg.outdeg + 7'd1;
                        end
                    end
                    mpag_pkg::REQ_REMOVE:
                    begin
                        if (bit_t)
                        begin
                            mem_we                = 1'b1;
                            mem_wdata.row[t_reg]  = 1'b0;
                            mem_wdata.deg         = rdata_reg.deg - 8'd1;
                            mem_wdata.outdeg      = rdata_reg.outdeg - 7'd1;
                        end
                    end
                    mpag_pkg::REQ_CHOOSE:
                        pass_next = mpag_pkg::PASS_SUM;
                    mpag_pkg::REQ_OUTE:
                        pass_next = mpag_pkg::PASS_CNT;
                    default:
                        pass_next = pass_reg;
                endcase
            end
            mpag_pkg::S_RDT:
                mem_raddr = t_reg;
            mpag_pkg::S_UPT:
            begin
                // destination side of the edge; sees the source write on a self loop
                mem_we           = 1'b1;
                mem_waddr        = t_reg;
                res_changed_next = 1'b1;
                if (req_reg == mpag_pkg::REQ_ADD)
                begin
                    mem_wdata.deg   = rdata_reg.deg + 8'd1;
                    edge_count_next = edge_count_reg + 13'd1;
                end
                else
                begin
                    mem_wdata.deg   = rdata_reg.deg - 8'd1;
                    edge_count_next = edge_count_reg - 13'd1;
                end
            end
            mpag_pkg::S_WALK:
            begin
                // issue the next table read, retire the one that came back
                if (issue)
                begin
                    idx_next  = idx_reg + 7'd1;
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[mpag_pkg::NODE_W-1:0];
                end
                if (pv_reg)
                begin
                    case (pass_reg) inside
                        mpag_pkg::PASS_SUM:
                        begin
                            if (cand_choose)
                                acc_next = acc_add;
                        end
                        mpag_pkg::PASS_SEL:
                        begin
                            if (cand_choose)
                                pre_next = pre_add;
                        end
                        mpag_pkg::PASS_CNT, mpag_pkg::PASS_PICK:
                        begin
                            if (cand_edge)
                                cnt_next = cnt_reg + 7'd1;
                        end
                        mpag_pkg::PASS_SRC:
                            s_next = s_add;
                        default:
                            s_next = s_reg;
                    endcase
                end
                if (walk_hit)
                begin
                    res_node_next  = pidx_reg;
                    res_found_next = 1'b1;
                end
            end
            mpag_pkg::S_MUL:
            begin
                thr_next  = thr_prod;
                pre_next  = '0;
                idx_next  = '0;
                pass_next = mpag_pkg::PASS_SEL;
            end
            mpag_pkg::S_DIV:
                div_start = 1'b1;
            mpag_pkg::S_DIVW:
            begin
                idx_next  = '0;
                cnt_next  = '0;
                s_next    = '0;
                pass_next = (req_reg == mpag_pkg::REQ_SOURCE) ? mpag_pkg::PASS_SRC
                                                              : mpag_pkg::PASS_PICK;
            end
            mpag_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, node_count_reg, edge_count_reg, res_node_reg};
                    m_user_next  = {res_changed_reg, res_found_reg};
                end
            end
            default:
                pv_next = 1'b0;
        endcase
    end

    // node table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mpag_pkg::S_IDLE;
            pass_reg       <= mpag_pkg::PASS_SUM;
            node_count_reg <= '0;
            edge_count_reg <= '0;
            alpha_reg      <= '0;
            pv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            node_count_reg <= node_count_next;
            edge_count_reg <= edge_count_next;
            alpha_reg      <= alpha_next;
            pv_reg         <= pv_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        f_reg           <= f_next;
        t_reg           <= t_next;
        mod_reg         <= mod_next;
        rint_reg        <= rint_next;
        rfrac_reg       <= rfrac_next;
        row_reg         <= row_next;
        modf_reg        <= modf_next;
        idx_reg         <= idx_next;
        pidx_reg        <= pidx_next;
        acc_reg         <= acc_next;
        pre_reg         <= pre_next;
        thr_reg         <= thr_next;
        cnt_reg         <= cnt_next;
        s_reg           <= s_next;
        res_node_reg    <= res_node_next;
        res_found_reg   <= res_found_next;
        res_changed_reg <= res_changed_next;
        m_data_reg      <= m_data_next;
        m_user_reg      <= m_user_next;
    end

    mpag_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rint_reg),
        .divisor  (div_den),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign s_tready  = (state_reg == mpag_pkg::S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign cfg_ready = 1'b1;

    // node count never passes the table size
    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= mpag_pkg::CNT_W'(mpag_pkg::MAX_NODES))
        else $error("node count beyond table size");

    // one item at a time: an accepted item drops ready
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("input accepted while busy");

    // edge count moves only in the destination update step
    a_edge_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mpag_pkg::S_UPT) |=> (edge_count_reg == $past(edge_count_reg)))
        else $error("edge count changed outside update");

    // remainder completes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mpag_pkg::S_DIVW))
        else $error("remainder done while not waiting");

endmodule
`default_nettype wire

// ===== rtl/mpag_rem.sv =====
// Bit-serial restoring remainder unit: one quotient bit per cycle.
`default_nettype none
module mpag_rem (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mpag_pkg::RINT_W-1:0] dividend,
    input  wire logic [mpag_pkg::EDGE_W-1:0] divisor,
    output logic                             done,
    output logic [mpag_pkg::EDGE_W-1:0]      rem
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [4:0]                      step_reg, step_next;
    logic [mpag_pkg::RINT_W-1:0]     num_reg, num_next;
    logic [mpag_pkg::EDGE_W-1:0]     den_reg, den_next;
    logic [mpag_pkg::EDGE_W-1:0]     rem_reg, rem_next;
    logic [mpag_pkg::EDGE_W:0]       trial;
    logic [mpag_pkg::EDGE_W:0]       diff;

    always_comb
    begin
        trial     = {rem_reg, num_reg[mpag_pkg::RINT_W-1]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 5'(mpag_pkg::RINT_W - 1);
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            rem_next = (trial >= {1'b0, den_reg}) ? diff[mpag_pkg::EDGE_W-1:0]
                                                  : trial[mpag_pkg::EDGE_W-1:0];
            num_next = {num_reg[mpag_pkg::RINT_W-2:0], 1'b0};
            if (step_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ===== test/modular_pref_attach_graph_store_chk.sv =====
// Checker for the graph store: predicts each result item from accepted requests and compares.
`timescale 1ns / 1ps
module modular_pref_attach_graph_store_chk (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic [mpag_pkg::NODE_W-1:0] node;
        logic                        found;
        logic                        changed;
        logic [mpag_pkg::EDGE_W-1:0] edges;
        logic [mpag_pkg::CNT_W-1:0]  nodes;
    } graph_result_t;

    logic [63:0]  adj [mpag_pkg::MAX_NODES];
    int unsigned  deg [mpag_pkg::MAX_NODES];
    int unsigned  odeg [mpag_pkg::MAX_NODES];
    logic [7:0]   tag [mpag_pkg::MAX_NODES];
    int unsigned  edge_cnt;
    int unsigned  node_cnt;
    logic [15:0]  alpha;
    graph_result_t expected_q[$];

    assign pending = expected_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic graph_result_t graph_apply(input logic [2:0] req, input logic [71:0] d);
        graph_result_t r;
        int unsigned f, t, rint, n, w, k, s, p;
        longint unsigned rfrac, acc, dg;
        longint unsigned pre [mpag_pkg::MAX_NODES];
        int unsigned who [mpag_pkg::MAX_NODES];
        logic fok, ftok;
        f = d[5:0];
        t = d[11:6];
        rint = d[50:20];
        rfrac = d[66:51];
        r = '0;
        fok = f < node_cnt;
        ftok = fok && t < node_cnt;
        n = 0;
        acc = 0;
        case (req)
            mpag_pkg::REQ_NEW:
                if (node_cnt < mpag_pkg::MAX_NODES)
                begin
                    r.node = node_cnt;
                    tag[node_cnt] = d[19:12];
                    node_cnt++;
                    r.found = 1;
                end
            mpag_pkg::REQ_ADD:
                if (ftok && !adj[f][t])
                begin
                    adj[f][t] = 1;
                    odeg[f]++;
                    deg[f]++;
                    deg[t]++;
                    edge_cnt++;
                    r.changed = 1;
                end
            mpag_pkg::REQ_REMOVE:
                if (ftok && adj[f][t])
                begin
                    adj[f][t] = 0;
                    odeg[f]--;
                    deg[f]--;
                    deg[t]--;
                    edge_cnt--;
                    r.changed = 1;
                end
            mpag_pkg::REQ_CHOOSE:
                if (fok)
                begin
                    for (w = 0; w < node_cnt; w++)
                        if (w != f && !adj[f][w])
                        begin
                            dg = deg[w];
                            if (tag[w] == tag[f])
                                acc += dg * (256 + longint'(alpha)) + 256;
                            else
                                acc += (dg + 1) * 256;
                            pre[n] = acc;
                            who[n] = w;
                            n++;
                        end
                    for (k = 0; k < n; k++)
                        if (pre[k] * 65536 >= rfrac * acc)
                        begin
                            r.node = who[k];
                            r.found = 1;
                            break;
                        end
                end
            mpag_pkg::REQ_OUTE:
                if (fok)
                begin
                    for (w = 0; w < node_cnt; w++)
                        if (w != f && adj[f][w])
                        begin
                            who[n] = w;
                            n++;
                        end
                    if (n > 0)
                    begin
                        r.node = who[rint % n];
                        r.found = 1;
                    end
                end
            mpag_pkg::REQ_SOURCE:
                if (edge_cnt > 0)
                begin
                    p = rint % edge_cnt;
                    s = 0;
                    for (w = 0; w < node_cnt; w++)
                    begin
                        s += odeg[w];
                        if (s > p)
                        begin
                            r.node = w;
                            r.found = 1;
                            break;
                        end
                    end
                end
            mpag_pkg::REQ_TEST:
                if (ftok && adj[f][t])
                    r.found = 1;
            default: ;
        endcase
        r.edges = edge_cnt;
        r.nodes = node_cnt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        graph_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < mpag_pkg::MAX_NODES; i++)
            begin
                adj[i] = '0;
                deg[i] = 0;
                odeg[i] = 0;
                tag[i] = '0;
            end
            edge_cnt = 0;
            node_cnt = 0;
            alpha = '0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                alpha = cfg_data;
            if (s_tvalid && s_tready)
                expected_q.push_back(graph_apply(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected result item", 1, 0);
                else
                begin
                    e = expected_q.pop_front();
                    if (m_tdata[5:0] != e.node)
                        report("node_id", m_tdata[5:0], e.node);
                    if (m_tuser[0] != e.found)
                        report("found", m_tuser[0], e.found);
                    if (m_tuser[1] != e.changed)
                        report("changed", m_tuser[1], e.changed);
                    if (m_tdata[18:6] != e.edges)
                        report("edge_total", m_tdata[18:6], e.edges);
                    if (m_tdata[25:19] != e.nodes)
                        report("node_total", m_tdata[25:19], e.nodes);
                end
            end
        end
    end
endmodule

// ===== test/modular_pref_attach_graph_store_tb.sv =====
// Testbench top: drives requests and alpha writes into the graph store and gives the verdict.
`timescale 1ns / 1ps
module modular_pref_attach_graph_store_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          hold_off;     // cycles left in a forced long receiver stall

    localparam int CYCLE_LIMIT = 900000;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    modular_pref_attach_graph_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    modular_pref_attach_graph_store_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("modular_pref_attach_graph_store_tb: FAIL");
            $finish;
        end
    end

    // Pick a gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off = hold_off - 1;
            end
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Offer one item and hold it until accepted; valid stays up for a following item.
    task automatic send_req(input logic [2:0] req, input logic [5:0] f, input logic [5:0] t,
                            input logic [7:0] tag, input logic [30:0] rint,
                            input logic [15:0] rfrac, input bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        repeat (g)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'd0, rfrac, rint, tag, t, f};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait out all results.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Wait out all results plus the block's tail, then write alpha.
    task automatic write_alpha(input logic [15:0] value);
        drain();
        repeat (200) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random request biased toward well-formed operands among created nodes.
    task automatic send_random(input int n_made, input bit burst);
        logic [2:0] req;
        int hi;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            req = mpag_pkg::REQ_NEW;
        else if (roll < 38)
            req = mpag_pkg::REQ_ADD;
        else if (roll < 48)
            req = mpag_pkg::REQ_REMOVE;
        else if (roll < 64)
            req = mpag_pkg::REQ_CHOOSE;
        else if (roll < 76)
            req = mpag_pkg::REQ_OUTE;
        else if (roll < 86)
            req = mpag_pkg::REQ_SOURCE;
        else if (roll < 97)
            req = mpag_pkg::REQ_TEST;
        else
            req = REQ_UNUSED;
        // Mostly valid node indexes, sometimes any index.
        hi = (n_made > 0 && $urandom_range(0, 9) != 0) ? n_made - 1 : 63;
        send_req(req, $urandom_range(0, hi), $urandom_range(0, hi),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 2),
                 $urandom_range(0, 31'h7fffffff), $urandom_range(0, 16'hffff), burst);
    endtask

    initial
    begin
        int made;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        cycle_count = 0;
        hold_off    = 0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: selections on an empty store, then a small graph.
        send_req(mpag_pkg::REQ_SOURCE, 0, 0, 0, 31'h7fffffff, 0, 0);
        send_req(mpag_pkg::REQ_CHOOSE, 0, 0, 0, 0, 16'hffff, 0);
        send_req(mpag_pkg::REQ_ADD, 0, 1, 0, 0, 0, 0);            // uncreated node
        send_req(mpag_pkg::REQ_NEW, 0, 0, 8'hff, 0, 0, 0);
        send_req(mpag_pkg::REQ_NEW, 0, 0, 8'hff, 0, 0, 0);
        send_req(mpag_pkg::REQ_NEW, 0, 0, 8'h00, 0, 0, 0);
        send_req(mpag_pkg::REQ_ADD, 0, 0, 0, 0, 0, 0);            // self loop
        send_req(mpag_pkg::REQ_ADD, 0, 1, 0, 0, 0, 0);
        send_req(mpag_pkg::REQ_ADD, 0, 1, 0, 0, 0, 0);            // duplicate
        send_req(mpag_pkg::REQ_ADD, 2, 63, 0, 0, 0, 0);           // out of range
        send_req(mpag_pkg::REQ_TEST, 0, 1, 0, 0, 0, 0);
        send_req(mpag_pkg::REQ_TEST, 1, 0, 0, 0, 0, 0);
        send_req(mpag_pkg::REQ_CHOOSE, 1, 0, 0, 0, 16'h0000, 0);
        send_req(mpag_pkg::REQ_CHOOSE, 1, 0, 0, 0, 16'hffff, 0);
        send_req(mpag_pkg::REQ_OUTE, 0, 0, 0, 31'h7fffffff, 0, 0);
        send_req(mpag_pkg::REQ_OUTE, 2, 0, 0, 0, 0, 0);           // no out-neighbor
        send_req(mpag_pkg::REQ_SOURCE, 0, 0, 0, 31'h7fffffff, 0, 0);
        send_req(mpag_pkg::REQ_REMOVE, 0, 1, 0, 0, 0, 0);
        send_req(mpag_pkg::REQ_REMOVE, 0, 1, 0, 0, 0, 0);         // already gone
        send_req(REQ_UNUSED, 63, 63, 8'hff, 31'h7fffffff, 16'hffff, 0);
        made = 3;

        // Random phases across alpha settings, extremes included.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_alpha(16'h0000);
                1: write_alpha(16'hffff);
                2: write_alpha(16'h0100);
                3: write_alpha($urandom_range(0, 16'hffff));
                default: write_alpha(16'h8000);
            endcase
            if (ph == 2)
                hold_off = 400;   // long receiver stall while requests keep coming
            for (int i = 0; i < 155; i++)
            begin
                send_random(made, ph == 2 && i < 40);
                if (s_tuser == mpag_pkg::REQ_NEW && made < mpag_pkg::MAX_NODES)
                    made++;
            end
        end

        // Fill the store past its limit, then probe it full.
        for (int i = 0; i < 66; i++)
            send_req(mpag_pkg::REQ_NEW, 0, 0, $urandom_range(0, 255), 0, 0, 0);
        send_req(mpag_pkg::REQ_ADD, 63, 63, 0, 0, 0, 0);
        send_req(mpag_pkg::REQ_CHOOSE, 63, 0, 0, 0, $urandom_range(0, 16'hffff), 0);
        send_req(mpag_pkg::REQ_SOURCE, 0, 0, 0, $urandom_range(0, 31'h7fffffff), 0, 0);

        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("modular_pref_attach_graph_store_tb: PASS");
        else
            $display("modular_pref_attach_graph_store_tb: FAIL");
        $finish;
    end
endmodule
